// File: sv/cpu_frequency_governor_macros.svh
// Assertion macros shared by the governor checker.
// Used by cfgov_checker.sv; no other dependencies.
`ifndef CPU_FREQUENCY_GOVERNOR_MACROS_SVH
`define CPU_FREQUENCY_GOVERNOR_MACROS_SVH

// Clocked assertion, muted while reset is held
`define CFGOV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also checks through reset
`define CFGOV_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/cfgov_pkg.sv
// Package for the CPU frequency governor: widths, profile layout, shared types.
// No dependencies; imported by every governor module.
`timescale 1ns / 1ps

package cfgov_pkg;

  // counter geometry
  localparam int CW      = 32;  // cumulative counter width
  localparam int NTS     = 6;   // number of time counters (idle is the last)
  localparam int CARRY_W = $clog2(NTS);
  localparam int SUM_W   = CARRY_W + 1;
  localparam int TOT_W   = CW + CARRY_W;
  localparam int BIT_W   = $clog2(CW);

  // percent values and divider geometry
  localparam int PCT_W   = 7;
  localparam int STEP_W  = $clog2(PCT_W);
  localparam int NUM_W   = CW + PCT_W;
  localparam int DSH_W   = TOT_W + PCT_W - 1;
  localparam int TEMP_W  = 12;
  localparam int INRT_W  = 8;
  localparam int PROF_W  = 51;
  localparam int CFG_IDX_W = 1;

  localparam logic [PCT_W-1:0] FULL_SCALE = 7'd100;

  localparam logic [PROF_W-1:0] BATTERY_RESET = 51'd6873500070400;
  localparam logic [PROF_W-1:0] WALL_RESET    = 51'd6873353269760;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BATTERY = 1'b0,
    REG_WALL    = 1'b1
  } cfg_reg_t;

  // packed profile register layout
  typedef struct packed {
    logic [7:0]       templimit;
    logic [PCT_W-1:0] up;
    logic [INRT_W-1:0] inertia;
    logic [PCT_W-1:0] down;
    logic [PCT_W-1:0] threshold;
    logic [PCT_W-1:0] max;
    logic [PCT_W-1:0] min;
  } profile_t;

  typedef logic [NTS-1:0][CW-1:0] cnt_vec_t;

  // control of the bit-serial delta unit
  typedef struct packed {
    logic prime;    // load previous counters directly
    logic capture;  // load current counters, clear borrows and carry
    logic shift;    // one bit step
  } delta_ctl_t;

  // policy result for one tick
  typedef struct packed {
    logic [PCT_W-1:0]  level;
    logic              set_freq;
    logic [PCT_W-1:0]  eff_max;
    logic [INRT_W-1:0] inertia;
  } gov_res_t;

  function automatic logic [PCT_W-1:0] sat100(input logic [PCT_W-1:0] v);
    return (v > FULL_SCALE) ? FULL_SCALE : v;
  endfunction

endpackage

// File: sv/cfgov_delta_acc.sv
// Bit-serial counter delta unit: per-counter serial subtract and column sum.
// Depends on cfgov_pkg.
`timescale 1ns / 1ps

module cfgov_delta_acc (
  input  logic                        clk,
  input  cfgov_pkg::delta_ctl_t       ctl,
  input  cfgov_pkg::cnt_vec_t         cnt_in,
  output logic [cfgov_pkg::TOT_W-1:0] total,
  output logic [cfgov_pkg::CW-1:0]    idle
);
  import cfgov_pkg::*;

  cnt_vec_t            cur_r;
  cnt_vec_t            prev_r;
  logic [NTS-1:0]      brw_r;
  logic [NTS-1:0]      brw_nxt;
  logic [NTS-1:0]      dbit;
  logic [CARRY_W-1:0]  carry_r;
  logic [CW-1:0]       tot_r;
  logic [CW-1:0]       idle_r;
  logic [SUM_W-1:0]    col;

  // one bit of every delta, and the column sum with the running carry
  always_comb begin
    col = SUM_W'(carry_r);
    for (int i = 0; i < NTS; i++) begin
      dbit[i]    = cur_r[i][0] ^ prev_r[i][0] ^ brw_r[i];
      brw_nxt[i] = (~cur_r[i][0] & prev_r[i][0]) |
                   (~(cur_r[i][0] ^ prev_r[i][0]) & brw_r[i]);
      col        = col + SUM_W'(dbit[i]);
    end
  end

  // shift registers, LSB first; current bits flow into the previous slots
  always_ff @(posedge clk) begin
    if (ctl.prime) begin
      prev_r <= cnt_in;
    end
    if (ctl.capture) begin
      cur_r   <= cnt_in;
      brw_r   <= '0;
      carry_r <= '0;
    end else if (ctl.shift) begin
      for (int i = 0; i < NTS; i++) begin
        cur_r[i]  <= cur_r[i] >> 1;
        prev_r[i] <= {cur_r[i][0], prev_r[i][CW-1:1]};
      end
      brw_r   <= brw_nxt;
      carry_r <= col[SUM_W-1:1];
      tot_r   <= {col[0], tot_r[CW-1:1]};
      idle_r  <= {dbit[NTS-1], idle_r[CW-1:1]};
    end
  end

  assign total = {carry_r, tot_r};
  assign idle  = idle_r;

endmodule

// File: sv/cfgov_div.sv
// Restoring divider for floor(100*idle/total), one quotient bit per cycle.
// Depends on cfgov_pkg.
`timescale 1ns / 1ps

module cfgov_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cfgov_pkg::CW-1:0]    idle,
  input  logic [cfgov_pkg::TOT_W-1:0] total,
  output logic                        busy,
  output logic [cfgov_pkg::PCT_W-1:0] quo
);
  import cfgov_pkg::*;

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [NUM_W-1:0]  rem_r;
  logic [DSH_W-1:0]  dsh_r;
  logic [PCT_W-1:0]  quo_r;
  logic [DSH_W-1:0]  rem_ext;
  logic              ge;

  // trial subtract against the shifted divisor
  always_comb begin
    rem_ext = DSH_W'(rem_r);
    ge      = (rem_ext >= dsh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (step_r == '0)) begin
      busy_r <= 1'b0;
    end
  end

  // numerator product registered on start, then one step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= NUM_W'(idle) * NUM_W'(FULL_SCALE);
      dsh_r  <= DSH_W'(total) << (PCT_W - 1);
      step_r <= STEP_W'(PCT_W - 1);
      quo_r  <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= NUM_W'(rem_ext - dsh_r);
      end
      dsh_r  <= dsh_r >> 1;
      quo_r  <= {quo_r[PCT_W-2:0], ge};
      step_r <= step_r - 1'b1;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

// File: sv/cfgov_policy.sv
// Governor policy: profile selection, thermal maximum, level and inertia state.
// Depends on cfgov_pkg.
`timescale 1ns / 1ps

module cfgov_policy (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         update,
  input  logic                         on_wall,
  input  logic [cfgov_pkg::TEMP_W-1:0] temp,
  input  logic [cfgov_pkg::PCT_W-1:0]  load,
  input  cfgov_pkg::profile_t          battery,
  input  cfgov_pkg::profile_t          wall,
  output cfgov_pkg::gov_res_t          res
);
  import cfgov_pkg::*;

  logic              mode_loaded_r;
  logic              active_mode_r;
  logic [PCT_W-1:0]  eff_max_r;
  logic [PCT_W-1:0]  level_r;
  logic [INRT_W-1:0] inertia_r;

  profile_t          prof;
  logic [PCT_W-1:0]  pmin;
  logic [PCT_W-1:0]  emax0;
  logic [PCT_W-1:0]  emax1;
  logic [PCT_W:0]    up_sum;
  logic [PCT_W:0]    dn_floor;

  always_comb begin
    prof  = on_wall ? wall : battery;
    pmin  = sat100(prof.min);
    // profile load on first tick or power source change
    emax0 = (!mode_loaded_r || (active_mode_r != on_wall)) ? sat100(prof.max) : eff_max_r;

    // thermal step of one
    emax1 = emax0;
    if (prof.templimit != '0) begin
      if (temp > {prof.templimit, 4'b0000}) begin
        if (emax0 > pmin) begin
          emax1 = emax0 - 1'b1;
        end
      end else if (emax0 < FULL_SCALE) begin
        emax1 = emax0 + 1'b1;
      end
    end

    up_sum   = {1'b0, level_r} + {1'b0, prof.up};
    dn_floor = {1'b0, pmin} + {1'b0, prof.down};

    res.eff_max  = emax1;
    res.level    = level_r;
    res.inertia  = inertia_r;
    res.set_freq = 1'b0;
    if (load > prof.threshold) begin
      // up path
      res.level    = sat100((up_sum < {1'b0, emax1}) ? up_sum[PCT_W-1:0] : emax1);
      res.set_freq = 1'b1;
      if (inertia_r < prof.inertia) begin
        res.inertia = inertia_r + 1'b1;
      end
    end else if (inertia_r == '0) begin
      // down path, clamped at min
      res.level    = ({1'b0, level_r} < dn_floor) ? pmin : (level_r - prof.down);
      res.set_freq = 1'b1;
    end else begin
      res.inertia = inertia_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_loaded_r <= 1'b0;
      active_mode_r <= 1'b0;
      eff_max_r     <= FULL_SCALE;
      level_r       <= '0;
      inertia_r     <= '0;
    end else if (update) begin
      mode_loaded_r <= 1'b1;
      active_mode_r <= on_wall;
      eff_max_r     <= res.eff_max;
      level_r       <= res.level;
      inertia_r     <= res.inertia;
    end
  end

endmodule

// File: sv/cpu_frequency_governor.sv
// CPU frequency governor top level. An accepted word passes through the bit-serial
// delta pass over its 32-bit counters and the divider (7-bit quotient, one bit per
// cycle); in_stall holds off the next word until its result is registered.
// The first word after reset only primes the counters and gives no result.
// Synchronous active-low reset restores the profile registers and clears state.
`timescale 1ns / 1ps

module cpu_frequency_governor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cfgov_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cfgov_pkg::PROF_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_on_wall,
  input  logic [cfgov_pkg::TEMP_W-1:0]  in_temp_sixteenths,
  input  logic [cfgov_pkg::CW-1:0]      in_user_ticks,
  input  logic [cfgov_pkg::CW-1:0]      in_nice_ticks,
  input  logic [cfgov_pkg::CW-1:0]      in_system_ticks,
  input  logic [cfgov_pkg::CW-1:0]      in_spin_ticks,
  input  logic [cfgov_pkg::CW-1:0]      in_interrupt_ticks,
  input  logic [cfgov_pkg::CW-1:0]      in_idle_ticks,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cfgov_pkg::PCT_W-1:0]   out_frequency_percent,
  output logic                          out_set_frequency,
  output logic [cfgov_pkg::PCT_W-1:0]   out_load_percent,
  output logic [cfgov_pkg::PCT_W-1:0]   out_thermal_max,
  output logic [cfgov_pkg::INRT_W-1:0]  out_inertia_count,
  output logic                          out_no_elapsed_time
);
  import cfgov_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DIVST,
    S_DIV,
    S_UPD
  } state_t;

  state_t            state_r;
  logic              primed_r;
  logic [BIT_W-1:0]  bitcnt_r;
  logic              on_wall_r;
  logic [TEMP_W-1:0] temp_r;
  profile_t          battery_r;
  profile_t          wall_r;

  logic              out_valid_r;
  logic [PCT_W-1:0]  freq_r;
  logic              setf_r;
  logic [PCT_W-1:0]  load_r;
  logic [PCT_W-1:0]  tmax_r;
  logic [INRT_W-1:0] inertia_r;
  logic              no_time_r;

  delta_ctl_t        dctl;
  cnt_vec_t          cnt_in;
  logic [TOT_W-1:0]  total;
  logic [CW-1:0]     idle;
  logic              div_start;
  logic              div_busy;
  logic [PCT_W-1:0]  quo;
  logic              in_acc;
  logic              out_free;
  logic              upd;
  logic              no_time;
  logic [PCT_W-1:0]  load;
  gov_res_t          res;

  // counter order: idle last
  assign cnt_in = {in_idle_ticks, in_interrupt_ticks, in_spin_ticks,
                   in_system_ticks, in_nice_ticks, in_user_ticks};

  // handshake and sequencing strobes
  always_comb begin
    in_stall     = (state_r != S_IDLE);
    in_acc       = in_valid && !in_stall;
    out_free     = !out_valid_r || !out_stall;
    dctl.prime   = in_acc && !primed_r;
    dctl.capture = in_acc && primed_r;
    dctl.shift   = (state_r == S_SHIFT);
    div_start    = (state_r == S_DIVST);
    upd          = (state_r == S_UPD) && out_free;
    no_time      = (total == '0);
    load         = no_time ? '0 : (FULL_SCALE - quo);
  end

  // profile registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      battery_r <= BATTERY_RESET;
      wall_r    <= WALL_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BATTERY: battery_r <= cfg_data;
        REG_WALL:    wall_r    <= cfg_data;
        default:     ;
      endcase
    end
  end

  // sequencer and output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      primed_r    <= 1'b0;
      bitcnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        on_wall_r <= in_on_wall;
        temp_r    <= in_temp_sixteenths;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (primed_r) begin
              state_r  <= S_SHIFT;
              bitcnt_r <= '0;
            end else begin
              primed_r <= 1'b1;
            end
          end
        end
        S_SHIFT: begin
          bitcnt_r <= bitcnt_r + 1'b1;
          if (bitcnt_r == BIT_W'(CW - 1)) begin
            state_r <= S_DIVST;
          end
        end
        S_DIVST: state_r <= S_DIV;
        S_DIV: begin
          if (!div_busy) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (upd) begin
        out_valid_r <= 1'b1;
        freq_r      <= res.level;
        setf_r      <= res.set_freq;
        load_r      <= load;
        tmax_r      <= res.eff_max;
        inertia_r   <= res.inertia;
        no_time_r   <= no_time;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  cfgov_delta_acc u_delta (
    .clk    (clk),
    .ctl    (dctl),
    .cnt_in (cnt_in),
    .total  (total),
    .idle   (idle)
  );

  cfgov_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .idle  (idle),
    .total (total),
    .busy  (div_busy),
    .quo   (quo)
  );

  cfgov_policy u_policy (
    .clk     (clk),
    .rst_n   (rst_n),
    .update  (upd),
    .on_wall (on_wall_r),
    .temp    (temp_r),
    .load    (load),
    .battery (battery_r),
    .wall    (wall_r),
    .res     (res)
  );

  assign out_valid             = out_valid_r;
  assign out_frequency_percent = freq_r;
  assign out_set_frequency     = setf_r;
  assign out_load_percent      = load_r;
  assign out_thermal_max       = tmax_r;
  assign out_inertia_count     = inertia_r;
  assign out_no_elapsed_time   = no_time_r;

endmodule

// File: sv/cfgov_checker.sv
// Port-level checks for the CPU frequency governor, bound to the top level.
// Depends on cfgov_pkg and cpu_frequency_governor_macros.svh.
`timescale 1ns / 1ps
`include "cpu_frequency_governor_macros.svh"

module cfgov_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [cfgov_pkg::PCT_W-1:0]   out_frequency_percent,
  input logic [cfgov_pkg::PCT_W-1:0]   out_load_percent,
  input logic [cfgov_pkg::PCT_W-1:0]   out_thermal_max,
  input logic                          out_no_elapsed_time
);
  import cfgov_pkg::*;

  logic               held;
  logic [2*PCT_W-1:0] held_bits;
  logic               bad_load;
  logic               pct_high;

  // conditions seen on the result word
  always_comb begin
    held      = out_valid && out_stall;
    held_bits = {out_load_percent, out_frequency_percent};
    bad_load  = out_valid && out_no_elapsed_time && (out_load_percent != '0);
    pct_high  = out_valid && ((out_load_percent > FULL_SCALE) ||
                              (out_thermal_max > FULL_SCALE) ||
                              (out_frequency_percent > FULL_SCALE));
  end

  // a stalled result word holds
  `CFGOV_ASSERT(a_out_hold, held |=> out_valid && $stable(held_bits), "stalled word changed")

  // zero elapsed time always reports zero load
  `CFGOV_ASSERT(a_no_time_load, !bad_load, "load nonzero with no elapsed time")

  // percentages stay within full scale
  `CFGOV_ASSERT(a_pct_range, !pct_high, "percentage above full scale")

  // after reset the block is idle and empty
  `CFGOV_ASSERT_RST(a_reset_idle, !rst_n |=> !in_stall && !out_valid, "not idle after reset")

endmodule

bind cpu_frequency_governor cfgov_checker u_cfgov_checker (.*);

// File: test/cfgov_tick_checker.sv
// Scoreboard for the CPU frequency governor: follows the config port and both channels,
// predicts each governor tick and compares every result word. Depends on cfgov_pkg.
`timescale 1ns / 1ps

module cfgov_tick_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cfgov_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cfgov_pkg::PROF_W-1:0]    cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_on_wall,
  input  logic [cfgov_pkg::TEMP_W-1:0]    in_temp_sixteenths,
  input  logic [cfgov_pkg::CW-1:0]        in_user_ticks,
  input  logic [cfgov_pkg::CW-1:0]        in_nice_ticks,
  input  logic [cfgov_pkg::CW-1:0]        in_system_ticks,
  input  logic [cfgov_pkg::CW-1:0]        in_spin_ticks,
  input  logic [cfgov_pkg::CW-1:0]        in_interrupt_ticks,
  input  logic [cfgov_pkg::CW-1:0]        in_idle_ticks,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [cfgov_pkg::PCT_W-1:0]     out_frequency_percent,
  input  logic                            out_set_frequency,
  input  logic [cfgov_pkg::PCT_W-1:0]     out_load_percent,
  input  logic [cfgov_pkg::PCT_W-1:0]     out_thermal_max,
  input  logic [cfgov_pkg::INRT_W-1:0]    out_inertia_count,
  input  logic                            out_no_elapsed_time,
  output int                              mismatches,
  output int                              pending
);
  import cfgov_pkg::*;

  // one expected result word
  typedef struct packed {
    logic [PCT_W-1:0]  level;
    logic              set_freq;
    logic [PCT_W-1:0]  load;
    logic [PCT_W-1:0]  ceiling;
    logic [INRT_W-1:0] inertia;
    logic              no_time;
  } tick_result_t;

  tick_result_t expected_ticks[$];
  tick_result_t want;

  // governor state as this side sees it
  profile_t          batt_prof, wall_prof;
  cnt_vec_t          last_ctr;
  logic              primed, active_wall, mode_loaded;
  logic [PCT_W-1:0]  eff_max, level;
  logic [INRT_W-1:0] inertia;

  initial mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
    if (got !== exp_v)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp_v));
  endtask

  function automatic logic [PCT_W-1:0] cap_pct(input logic [PCT_W-1:0] v);
    return (v > FULL_SCALE) ? FULL_SCALE : v;
  endfunction

  // one governor tick: deltas, profile load, thermal step, load, level policy
  task automatic predict_tick(input logic wall, input logic [TEMP_W-1:0] temp,
                              input cnt_vec_t now);
    profile_t         prof;
    logic [CW-1:0]    delta, idle_d;
    logic [TOT_W-1:0] total;
    longint unsigned  quot;
    logic [PCT_W-1:0] floor_pct, load;
    int               lowered;
    tick_result_t     r;

    // first word only primes the counters
    if (!primed) begin
      last_ctr = now;
      primed = 1'b1;
      return;
    end

    total = '0;
    for (int i = 0; i < NTS; i++) begin
      delta = now[i] - last_ctr[i];
      total = total + delta;
    end
    idle_d = now[NTS-1] - last_ctr[NTS-1];
    last_ctr = now;

    // first tick or power source change reloads the ceiling
    if (!mode_loaded || active_wall != wall) begin
      active_wall = wall;
      mode_loaded = 1'b1;
      prof = wall ? wall_prof : batt_prof;
      eff_max = cap_pct(prof.max);
    end
    prof = active_wall ? wall_prof : batt_prof;
    floor_pct = cap_pct(prof.min);

    // thermal ceiling moves by one per tick
    if (prof.templimit != '0) begin
      if (temp > {prof.templimit, 4'b0000}) begin
        if (eff_max > floor_pct) eff_max = eff_max - 1'b1;
      end else if (eff_max < FULL_SCALE) begin
        eff_max = eff_max + 1'b1;
      end
    end

    // busy percentage, zero when no time elapsed
    if (total == '0) begin
      load = '0;
    end else begin
      quot = (64'(idle_d) * 64'd100) / 64'(total);
      if (quot > 100) quot = 100;
      load = 7'(100 - quot);
    end

    r.set_freq = 1'b1;
    if (load > prof.threshold) begin
      if (int'(level) + int'(prof.up) < int'(eff_max)) level = level + prof.up;
      else level = eff_max;
      if (inertia < prof.inertia) inertia = inertia + 1'b1;
    end else if (inertia == '0) begin
      lowered = int'(level) - int'(prof.down);
      if (lowered < int'(floor_pct)) lowered = int'(floor_pct);
      if (lowered < 0) lowered = 0;
      level = 7'(lowered);
    end else begin
      inertia = inertia - 1'b1;
      r.set_freq = 1'b0;
    end

    r.level   = level;
    r.load    = load;
    r.ceiling = eff_max;
    r.inertia = inertia;
    r.no_time = (total == '0);
    expected_ticks.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      batt_prof   = BATTERY_RESET;
      wall_prof   = WALL_RESET;
      last_ctr    = '0;
      primed      = 1'b0;
      active_wall = 1'b0;
      mode_loaded = 1'b0;
      eff_max     = FULL_SCALE;
      level       = '0;
      inertia     = '0;
      expected_ticks.delete();
    end else begin
      // result word against the oldest expectation
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_ticks.size() == 0) begin
          report_mismatch("result word with no tick pending");
        end else begin
          want = expected_ticks.pop_front();
          check_field("frequency_percent", out_frequency_percent, want.level);
          check_field("set_frequency", out_set_frequency, want.set_freq);
          check_field("load_percent", out_load_percent, want.load);
          check_field("thermal_max", out_thermal_max, want.ceiling);
          check_field("inertia_count", out_inertia_count, want.inertia);
          check_field("no_elapsed_time", out_no_elapsed_time, want.no_time);
        end
      end
      // profile writes
      if (cfg_we === 1'b1) begin
        if (cfg_index == REG_BATTERY) batt_prof = cfg_data;
        else if (cfg_index == REG_WALL) wall_prof = cfg_data;
      end
      // accepted tick
      if (in_valid === 1'b1 && in_stall === 1'b0)
        predict_tick(in_on_wall, in_temp_sixteenths,
                     {in_idle_ticks, in_interrupt_ticks, in_spin_ticks,
                      in_system_ticks, in_nice_ticks, in_user_ticks});
    end
    pending = expected_ticks.size();
  end

endmodule

// File: test/cpu_frequency_governor_tb.sv
// Top of the governor testbench: clock, reset, profile writes, tick stimulus and
// receiver stalls; verdict from cfgov_tick_checker. Depends on cfgov_pkg and the RTL.
`timescale 1ns / 1ps

module cpu_frequency_governor_tb;
  import cfgov_pkg::*;

  localparam int DRAIN_CYCLES = 60;   // settle time after the last result
  localparam int HOLD_CYCLES  = 400;  // long receiver hold-off

  bit                   clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PROF_W-1:0]    cfg_data;
  logic                 in_valid, in_stall, in_on_wall;
  logic [TEMP_W-1:0]    in_temp_sixteenths;
  logic [CW-1:0]        in_user_ticks, in_nice_ticks, in_system_ticks;
  logic [CW-1:0]        in_spin_ticks, in_interrupt_ticks, in_idle_ticks;
  logic                 out_valid, out_stall;
  logic [PCT_W-1:0]     out_frequency_percent, out_load_percent, out_thermal_max;
  logic                 out_set_frequency, out_no_elapsed_time;
  logic [INRT_W-1:0]    out_inertia_count;
  int                   mismatches, pending;

  // stimulus state
  cnt_vec_t ctr;                 // cumulative counters, [NTS-1] is idle
  profile_t batt_cfg, wall_cfg;
  int       idle_pct, stall_pct;
  bit       hold_req, on_wall_now, heavy, hot;
  int       idle_tab[4]  = '{0, 58, 0, 14};
  int       stall_tab[4] = '{0, 0, 58, 14};

  cpu_frequency_governor uut (.*);

  cfgov_tick_checker governor_check (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver: random stall, or a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic profile_t pack_profile(input int mn, input int mx, input int thr,
                                            input int dn, input int inr, input int up,
                                            input int tl);
    profile_t p;
    p.min       = 7'(mn);
    p.max       = 7'(mx);
    p.threshold = 7'(thr);
    p.down      = 7'(dn);
    p.inertia   = 8'(inr);
    p.up        = 7'(up);
    p.templimit = 8'(tl);
    return p;
  endfunction

  // mostly usable profiles, sometimes raw bits
  function automatic profile_t random_profile();
    if ($urandom_range(0, 4) == 0) return profile_t'(51'({$urandom, $urandom}));
    return pack_profile($urandom_range(0, 50), $urandom_range(30, 127),
                        $urandom_range(0, 100), $urandom_range(0, 40),
                        $urandom_range(0, 12), $urandom_range(0, 60),
                        ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(30, 100));
  endfunction

  function automatic void bump(input cnt_vec_t d);
    for (int i = 0; i < NTS; i++) ctr[i] = ctr[i] + d[i];
  endfunction

  // offer one tick word with the current counters, random sender gaps first
  task automatic send_tick(input logic wall, input logic [TEMP_W-1:0] temp);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_on_wall         <= wall;
    in_temp_sixteenths <= temp;
    in_user_ticks      <= ctr[0];
    in_nice_ticks      <= ctr[1];
    in_system_ticks    <= ctr[2];
    in_spin_ticks      <= ctr[3];
    in_interrupt_ticks <= ctr[4];
    in_idle_ticks      <= ctr[5];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering, let every result come out, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_profiles(input profile_t b, input profile_t w);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BATTERY;
    cfg_data  <= b;
    @(negedge clk);
    cfg_index <= REG_WALL;
    cfg_data  <= w;
    @(negedge clk);
    cfg_we    <= 1'b0;
    batt_cfg = b;
    wall_cfg = w;
  endtask

  // random tick: load and temperature follow runs, with some raw counter noise
  task automatic random_tick();
    cnt_vec_t          d;
    profile_t          p;
    int unsigned       roll, span, share, busy;
    int                t;
    logic [TEMP_W-1:0] temp;

    if ($urandom_range(0, 9) == 0) on_wall_now = ~on_wall_now;
    if ($urandom_range(0, 7) == 0) heavy = ~heavy;
    if ($urandom_range(0, 7) == 0) hot = ~hot;
    roll = $urandom_range(0, 99);
    d = '0;
    if (roll < 5) begin
      // no elapsed time
    end else if (roll < 10) begin
      for (int i = 0; i < NTS; i++) d[i] = $urandom;
    end else begin
      span  = $urandom_range(1, (roll < 20) ? 4000000 : 2000);
      share = heavy ? $urandom_range(0, 30) : $urandom_range(55, 100);
      if (roll < 12) share = 0;
      else if (roll < 14) share = 100;
      d[NTS-1] = span * share / 100;
      busy = span - d[NTS-1];
      for (int i = 0; i < NTS - 2; i++) begin
        d[i] = $urandom_range(0, busy);
        busy = busy - d[i];
      end
      d[NTS-2] = busy;
    end

    // aim the temperature around the active limit most of the time
    p = on_wall_now ? wall_cfg : batt_cfg;
    if (p.templimit != '0 && $urandom_range(0, 3) != 0) begin
      t = hot ? int'(p.templimit) * 16 + int'($urandom_range(1, 40))
              : int'(p.templimit) * 16 - int'($urandom_range(0, 40));
      if (t < 0) t = 0;
      if (t > 4095) t = 4095;
      temp = 12'(t);
    end else begin
      temp = 12'($urandom_range(0, 4095));
    end
    bump(d);
    send_tick(on_wall_now, temp);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_BATTERY;
    cfg_data = '0;
    in_valid = 1'b0;
    in_on_wall = 1'b0;
    in_temp_sixteenths = '0;
    in_user_ticks = '0;
    in_nice_ticks = '0;
    in_system_ticks = '0;
    in_spin_ticks = '0;
    in_interrupt_ticks = '0;
    in_idle_ticks = '0;
    idle_pct = 0;
    stall_pct = 0;
    batt_cfg = BATTERY_RESET;
    wall_cfg = WALL_RESET;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed ticks under the reset profiles; idle counter is leftmost
    ctr = {NTS{32'hFFFF_FFF0}};
    send_tick(1'b0, '0);
    bump({32'd10, 32'd5, 32'd0, 32'd3, 32'd0, 32'd2});
    send_tick(1'b0, 12'd100);
    bump('0);
    send_tick(1'b0, '1);
    bump({32'd1000, 160'd0});
    send_tick(1'b0, '1);
    bump({160'd0, 32'd1000});
    send_tick(1'b1, '0);
    bump('1);
    send_tick(1'b1, 12'd2048);
    bump({32'hFFFF_FFFF, 160'd0});
    send_tick(1'b0, '0);
    // busy run climbs and fills inertia, idle run drains it and steps down
    repeat (4) begin
      bump({32'd0, 96'd0, 32'd200, 32'd500});
      send_tick(1'b0, '1);
    end
    repeat (5) begin
      bump({32'd700, 160'd0});
      send_tick(1'b0, '0);
    end

    // every profile field at its top value
    wait_idle();
    write_profiles('1, '1);
    bump({32'd50, 128'd0, 32'd50});
    send_tick(1'b1, '1);
    bump({160'd0, 32'd100});
    send_tick(1'b0, '1);
    bump({32'd9, 160'd0});
    send_tick(1'b0, '0);

    // every profile field zero, thermal limit off
    wait_idle();
    write_profiles('0, '0);
    bump({160'd0, 32'd3});
    send_tick(1'b1, '0);
    bump({32'd3, 160'd0});
    send_tick(1'b0, '1);

    // minimum above maximum, limit of 50 degrees (800 sixteenths)
    wait_idle();
    write_profiles(pack_profile(90, 20, 50, 10, 2, 30, 50),
                   pack_profile(95, 10, 0, 5, 0, 127, 50));
    repeat (2) begin
      bump({160'd0, 32'd100});
      send_tick(1'b0, '1);
    end
    bump({32'd100, 160'd0});
    send_tick(1'b0, 12'd800);
    bump({160'd0, 32'd100});
    send_tick(1'b1, 12'd801);

    // random part: four idling phases, two profile settings each
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_profiles(random_profile(), random_profile());
      idle_pct  = idle_tab[ph / 2];
      stall_pct = stall_tab[ph / 2];
      if (ph == 1) hold_req = 1'b1;
      repeat (180) random_tick();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/cfgov_pkg.sv
sv/cfgov_delta_acc.sv
sv/cfgov_div.sv
sv/cfgov_policy.sv
sv/cpu_frequency_governor.sv
sv/cfgov_checker.sv
test/cfgov_tick_checker.sv
test/cpu_frequency_governor_tb.sv
